// ===== sv/fme_pkg.sv =====
`timescale 1ns / 1ps
// fme_pkg: shared types and constants for the fuzzy membership evaluator
// no dependencies; imported by fme_div, fuzzy_membership_eval_core and the test bench

package fme_pkg;

    localparam int DEF_VALUE_WIDTH = 16;
    localparam int PEAK_W          = 16;
    localparam int FRAC_W          = 15;
    localparam int CFG_IDX_W       = 3;

    localparam logic [PEAK_W-1:0] PEAK_ONE = PEAK_W'(32768);

    typedef enum logic [1:0] {
        SHAPE_STEP     = 2'd0,
        SHAPE_INV_STEP = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_TRAPEZE  = 2'd3
    } shape_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE_MODE  = 3'd0,
        REG_BREAK_ONE   = 3'd1,
        REG_BREAK_TWO   = 3'd2,
        REG_BREAK_THREE = 3'd3,
        REG_BREAK_FOUR  = 3'd4,
        REG_PEAK_LEVEL  = 3'd5
    } cfg_reg_t;

    // per item: take the quotient or a fixed degree
    typedef struct packed {
        logic              use_div;
        logic [PEAK_W-1:0] direct;
    } fme_ctl_t;

endpackage

// ===== sv/fuzzy_membership_eval_core.sv =====
`timescale 1ns / 1ps
// fuzzy_membership_eval_core: top level of the fuzzy membership evaluator
// depends on fme_pkg and fme_div
//
// usage
//   input channel: crisp_value with crisp_valid / crisp_stall; one item is
//   taken at each edge with crisp_valid high and crisp_stall low
//   output channel: membership with membership_valid / membership_stall,
//   one result item per input item, in order
//   config: cfg_valid / cfg_ready write port, cfg_index selects the register
//   (shape mode, four breakpoints, peak level); cfg_ready is always high,
//   writes only while no item is in flight
//   pipeline: input register, compare stage, multiplier stage, then the
//   15-stage divider (one quotient bit a stage) and the output register;
//   throughput one item per cycle while membership_stall stays low
//   reset: clears all valid bits and loads the register defaults (step
//   shape, breakpoints zero, peak 1.0)
//   stall: a stalled output holds its item; bubbles in the pipe still fill,
//   and crisp_stall rises only when every stage holds an item

module fuzzy_membership_eval_core #(
    parameter int VALUE_WIDTH = fme_pkg::DEF_VALUE_WIDTH,
    localparam int CFG_W = (VALUE_WIDTH > fme_pkg::PEAK_W) ? VALUE_WIDTH : fme_pkg::PEAK_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           crisp_valid,
    output logic                           crisp_stall,
    input  logic signed [VALUE_WIDTH-1:0]  crisp_value,
    output logic                           membership_valid,
    input  logic                           membership_stall,
    output logic [fme_pkg::PEAK_W-1:0]     membership,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]               cfg_data
);
    import fme_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int PROD_W = PEAK_W + VW;

    shape_mode_t           shape_reg;
    logic signed [VW-1:0]  b1_reg;
    logic signed [VW-1:0]  b2_reg;
    logic signed [VW-1:0]  b3_reg;
    logic signed [VW-1:0]  b4_reg;
    logic [PEAK_W-1:0]     peak_reg;
    logic [PEAK_W-1:0]     peak_clamp;

    logic                  v1_reg;
    logic signed [VW-1:0]  x1_reg;
    logic                  v2_reg;
    logic [VW-1:0]         num2_reg;
    logic [VW-1:0]         den2_reg;
    fme_ctl_t              ctl2_reg;
    logic [VW-1:0]         num2_next;
    logic [VW-1:0]         den2_next;
    fme_ctl_t              ctl2_next;
    logic                  v3_reg;
    logic [PROD_W-1:0]     prod3_reg;
    logic [VW-1:0]         den3_reg;
    fme_ctl_t              ctl3_reg;
    logic                  vo_reg;
    logic [PEAK_W-1:0]     mem_reg;

    logic                  adv1;
    logic                  adv2;
    logic                  adv3;
    logic                  advo;
    logic                  div_stall;
    logic                  div_valid;
    logic [FRAC_W-1:0]     div_quo;
    fme_ctl_t              div_ctl;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= SHAPE_STEP;
            b1_reg    <= '0;
            b2_reg    <= '0;
            b3_reg    <= '0;
            b4_reg    <= '0;
            peak_reg  <= PEAK_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SHAPE_MODE:  shape_reg <= shape_mode_t'(cfg_data[1:0]);
                REG_BREAK_ONE:   b1_reg    <= cfg_data[VW-1:0];
                REG_BREAK_TWO:   b2_reg    <= cfg_data[VW-1:0];
                REG_BREAK_THREE: b3_reg    <= cfg_data[VW-1:0];
                REG_BREAK_FOUR:  b4_reg    <= cfg_data[VW-1:0];
                REG_PEAK_LEVEL:  peak_reg  <= cfg_data[PEAK_W-1:0];
                default:         ;
            endcase
        end
    end

    assign peak_clamp = (peak_reg > PEAK_ONE) ? PEAK_ONE : peak_reg;

    // handshake chain
    assign advo        = !vo_reg || !membership_stall;
    assign adv3        = !v3_reg || !div_stall;
    assign adv2        = !v2_reg || adv3;
    assign adv1        = !v1_reg || adv2;
    assign crisp_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= crisp_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (advo)
            begin
                vo_reg <= div_valid;
            end
        end
    end

    // region decode and edge operands
    always_comb
    begin
        num2_next = '0;
        den2_next = VW'(1);
        ctl2_next = '{use_div: 1'b0, direct: '0};
        unique case (shape_reg)
            SHAPE_STEP:
            begin
                if (x1_reg <= b1_reg)
                begin
                    ctl2_next.direct = '0;
                end
                else if (x1_reg < b2_reg)
                begin
                    ctl2_next.use_div = 1'b1;
                    num2_next = x1_reg - b1_reg;
                    den2_next = b2_reg - b1_reg;
                end
                else
                begin
                    ctl2_next.direct = peak_clamp;
                end
            end
            SHAPE_INV_STEP:
            begin
                if (x1_reg <= b1_reg)
                begin
                    ctl2_next.direct = peak_clamp;
                end
                else if (x1_reg < b2_reg)
                begin
                    ctl2_next.use_div = 1'b1;
                    num2_next = b2_reg - x1_reg;
                    den2_next = b2_reg - b1_reg;
                end
                else
                begin
                    ctl2_next.direct = '0;
                end
            end
            SHAPE_TRIANGLE:
            begin
                if (x1_reg <= b1_reg)
                begin
                    ctl2_next.direct = '0;
                end
                else if (x1_reg < b2_reg)
                begin
                    ctl2_next.use_div = 1'b1;
                    num2_next = x1_reg - b1_reg;
                    den2_next = b2_reg - b1_reg;
                end
                else if (x1_reg == b2_reg)
                begin
                    ctl2_next.direct = peak_clamp;
                end
                else if (x1_reg < b3_reg)
                begin
                    ctl2_next.use_div = 1'b1;
                    num2_next = b3_reg - x1_reg;
                    den2_next = b3_reg - b2_reg;
                end
                else
                begin
                    ctl2_next.direct = '0;
                end
            end
            SHAPE_TRAPEZE:
            begin
                if (x1_reg <= b1_reg)
                begin
                    ctl2_next.direct = '0;
                end
                else if (x1_reg < b2_reg)
                begin
                    ctl2_next.use_div = 1'b1;
                    num2_next = x1_reg - b1_reg;
                    den2_next = b2_reg - b1_reg;
                end
                else if (x1_reg <= b3_reg)
                begin
                    ctl2_next.direct = peak_clamp;
                end
                else if (x1_reg < b4_reg)
                begin
                    ctl2_next.use_div = 1'b1;
                    num2_next = b4_reg - x1_reg;
                    den2_next = b4_reg - b3_reg;
                end
                else
                begin
                    ctl2_next.direct = '0;
                end
            end
            default:
            begin
                ctl2_next.direct = '0;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv1 && crisp_valid)
        begin
            x1_reg <= crisp_value;
        end
        if (adv2 && v1_reg)
        begin
            num2_reg <= num2_next;
            den2_reg <= den2_next;
            ctl2_reg <= ctl2_next;
        end
        if (adv3 && v2_reg)
        begin
            prod3_reg <= PROD_W'(peak_clamp) * PROD_W'(num2_reg);
            den3_reg  <= den2_reg;
            ctl3_reg  <= ctl2_reg;
        end
        if (advo && div_valid)
        begin
            mem_reg <= div_ctl.use_div ? PEAK_W'(div_quo) : div_ctl.direct;
        end
    end

    fme_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v3_reg),
        .in_stall     (div_stall),
        .in_dividend  (prod3_reg),
        .in_divisor   (den3_reg),
        .in_ctl       (ctl3_reg),
        .out_valid    (div_valid),
        .out_stall    (!advo),
        .out_quotient (div_quo),
        .out_ctl      (div_ctl)
    );

    assign membership_valid = vo_reg;
    assign membership       = mem_reg;

`ifndef SYNTHESIS
    a_edge_operands: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && ctl2_reg.use_div) |-> (den2_reg != '0 && num2_reg < den2_reg))
        else $error("edge operands out of range");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && ctl3_reg.use_div) |-> (den3_reg != '0))
        else $error("zero divisor entering divider");

    a_degree_bound: assert property (@(posedge clk) disable iff (!rst_n)
        membership_valid |-> (membership <= peak_clamp))
        else $error("membership above peak level");
`endif

endmodule

// ===== sv/fme_div.sv =====
`timescale 1ns / 1ps
// fme_div: pipelined restoring divider, one quotient bit per stage
// depends on fme_pkg; quotient is known to stay below 2**FRAC_W

module fme_div #(
    parameter int VALUE_WIDTH = fme_pkg::DEF_VALUE_WIDTH,
    localparam int PROD_W = fme_pkg::PEAK_W + VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [PROD_W-1:0]             in_dividend,
    input  logic [VALUE_WIDTH-1:0]        in_divisor,
    input  fme_pkg::fme_ctl_t             in_ctl,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fme_pkg::FRAC_W-1:0]    out_quotient,
    output fme_pkg::fme_ctl_t             out_ctl
);
    import fme_pkg::*;

    localparam int STEPS = FRAC_W;
    localparam int VW    = VALUE_WIDTH;

    logic [VW-1:0]     rem_reg [STEPS];
    logic [FRAC_W-1:0] low_reg [STEPS];
    logic [FRAC_W-1:0] quo_reg [STEPS];
    logic [VW-1:0]     den_reg [STEPS];
    fme_ctl_t          ctl_reg [STEPS];
    logic [STEPS-1:0]  vld_reg;
    logic [STEPS:0]    adv;

    assign adv[STEPS] = !out_stall;

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_stage
            logic              src_valid;
            logic [VW-1:0]     src_rem;
            logic [FRAC_W-1:0] src_low;
            logic [FRAC_W-1:0] src_quo;
            logic [VW-1:0]     src_den;
            fme_ctl_t          src_ctl;
            logic [VW:0]       trial;
            logic              ge;
            logic [VW-1:0]     rem_next;
            logic [FRAC_W-1:0] low_next;
            logic [FRAC_W-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_rem   = in_dividend[FRAC_W+VW-1:FRAC_W];
                assign src_low   = in_dividend[FRAC_W-1:0];
                assign src_quo   = '0;
                assign src_den   = in_divisor;
                assign src_ctl   = in_ctl;
            end
            else
            begin : g_next
                assign src_valid = vld_reg[k-1];
                assign src_rem   = rem_reg[k-1];
                assign src_low   = low_reg[k-1];
                assign src_quo   = quo_reg[k-1];
                assign src_den   = den_reg[k-1];
                assign src_ctl   = ctl_reg[k-1];
            end

            always_comb
            begin
                trial    = {src_rem, src_low[FRAC_W-1]};
                ge       = trial >= {1'b0, src_den};
                rem_next = ge ? VW'(trial - {1'b0, src_den}) : trial[VW-1:0];
                low_next = {src_low[FRAC_W-2:0], 1'b0};
                quo_next = {src_quo[FRAC_W-2:0], ge};
            end

            assign adv[k] = !vld_reg[k] || adv[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (adv[k])
                begin
                    vld_reg[k] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[k] && src_valid)
                begin
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= low_next;
                    quo_reg[k] <= quo_next;
                    den_reg[k] <= src_den;
                    ctl_reg[k] <= src_ctl;
                end
            end
        end
    endgenerate

    assign in_stall     = !adv[0];
    assign out_valid    = vld_reg[STEPS-1];
    assign out_quotient = quo_reg[STEPS-1];
    assign out_ctl      = ctl_reg[STEPS-1];

endmodule

// ===== dv/fuzzy_membership_eval_core_test.sv =====
`timescale 1ns / 1ps
// fuzzy_membership_eval_core_test: self-checking bench for the membership evaluator
// depends on fme_pkg and fuzzy_membership_eval_core; predicts each degree from the curve
// registers and checks results in order under random idle and stall

module fuzzy_membership_eval_core_test;
    import fme_pkg::*;

    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

    typedef struct {
        logic signed [15:0] crisp;
        logic [15:0]        degree;
    } degree_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  crisp_valid = 1'b0;
    logic                  crisp_stall;
    logic signed [15:0]    crisp_value = '0;
    logic                  membership_valid;
    logic                  membership_stall = 1'b0;
    logic [PEAK_W-1:0]     membership;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [15:0]           cfg_data = '0;

    logic signed [15:0]    crisp_backlog[$];
    degree_item_t          degree_due[$];
    degree_item_t          due_head;

    shape_mode_t           shape_cfg = SHAPE_STEP;
    logic signed [15:0]    brk_cfg[4] = '{default: '0};
    logic [15:0]           peak_cfg = PEAK_ONE;

    int                    gap_pct = 0;
    int                    stall_pct = 0;
    int                    errors = 0;
    int                    checked = 0;
    int                    curves = 0;

    fuzzy_membership_eval_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .crisp_valid      (crisp_valid),
        .crisp_stall      (crisp_stall),
        .crisp_value      (crisp_value),
        .membership_valid (membership_valid),
        .membership_stall (membership_stall),
        .membership       (membership),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] degree_of(logic signed [15:0] x);
        longint xv, b1, b2, b3, b4, pk, r;
        xv = x;
        b1 = brk_cfg[0];
        b2 = brk_cfg[1];
        b3 = brk_cfg[2];
        b4 = brk_cfg[3];
        pk = (peak_cfg > PEAK_ONE) ? PEAK_ONE : peak_cfg;
        r = 0;
        case (shape_cfg)
            SHAPE_STEP:
            begin
                if (xv <= b1) r = 0;
                else if (xv < b2) r = pk * (xv - b1) / (b2 - b1);
                else r = pk;
            end
            SHAPE_INV_STEP:
            begin
                if (xv <= b1) r = pk;
                else if (xv < b2) r = pk * (b2 - xv) / (b2 - b1);
                else r = 0;
            end
            SHAPE_TRIANGLE:
            begin
                if (xv <= b1) r = 0;
                else if (xv < b2) r = pk * (xv - b1) / (b2 - b1);
                else if (xv == b2) r = pk;
                else if (xv < b3) r = pk * (b3 - xv) / (b3 - b2);
                else r = 0;
            end
            default:
            begin
                if (xv <= b1) r = 0;
                else if (xv < b2) r = pk * (xv - b1) / (b2 - b1);
                else if (xv <= b3) r = pk;
                else if (xv < b4) r = pk * (b4 - xv) / (b4 - b3);
                else r = 0;
            end
        endcase
        return r[15:0];
    endfunction

    // half the picks near a breakpoint, where the edges and corners are
    function automatic logic signed [15:0] pick_crisp();
        int v, k, lo, hi;
        lo = brk_cfg[0];
        hi = brk_cfg[0];
        for (int i = 1; i < 4; i++)
        begin
            if (brk_cfg[i] < lo) lo = brk_cfg[i];
            if (brk_cfg[i] > hi) hi = brk_cfg[i];
        end
        case ($urandom_range(3))
            0: v = int'($urandom_range(65535)) - 32768;
            1, 2:
            begin
                k = $urandom_range(3);
                v = int'(brk_cfg[k]) + int'($urandom_range(6)) - 3;
            end
            default: v = lo + int'($urandom_range(hi - lo));
        endcase
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return 16'(v);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crisp_valid <= 1'b0;
            crisp_value <= '0;
        end
        else if (!crisp_valid || !crisp_stall)
        begin
            if (crisp_backlog.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                crisp_valid <= 1'b1;
                crisp_value <= crisp_backlog.pop_front();
            end
            else
            begin
                crisp_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            membership_stall <= 1'b0;
        else
            membership_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SHAPE_MODE:  shape_cfg = shape_mode_t'(cfg_data[1:0]);
                    REG_BREAK_ONE:   brk_cfg[0] = cfg_data;
                    REG_BREAK_TWO:   brk_cfg[1] = cfg_data;
                    REG_BREAK_THREE: brk_cfg[2] = cfg_data;
                    REG_BREAK_FOUR:  brk_cfg[3] = cfg_data;
                    REG_PEAK_LEVEL:  peak_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (crisp_valid && !crisp_stall)
                degree_due.push_back('{crisp: crisp_value, degree: degree_of(crisp_value)});
            if (membership_valid && !membership_stall)
            begin
                if (degree_due.size() == 0)
                begin
                    $display("%0t: membership expected none got %0d", $time, membership);
                    errors++;
                end
                else
                begin
                    due_head = degree_due.pop_front();
                    if (membership !== due_head.degree)
                    begin
                        $display("%0t: membership for crisp %0d expected %0d got %0d",
                                 $time, due_head.crisp, due_head.degree, membership);
                        errors++;
                    end
                    checked++;
                end
            end
        end
    end

    task automatic drain();
        do @(negedge clk);
        while (crisp_backlog.size() != 0 || crisp_valid || degree_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_curve(input shape_mode_t s, input int b1, input int b2,
                              input int b3, input int b4, input logic [15:0] pk);
        drain();
        write_reg(REG_SHAPE_MODE, 16'(s));
        write_reg(REG_BREAK_ONE, 16'(b1));
        write_reg(REG_BREAK_TWO, 16'(b2));
        write_reg(REG_BREAK_THREE, 16'(b3));
        write_reg(REG_BREAK_FOUR, 16'(b4));
        write_reg(REG_PEAK_LEVEL, pk);
        curves++;
    endtask

    task automatic push_crisp(input int v);
        crisp_backlog.push_back(16'(v));
    endtask

    initial
    begin : stimulus
        int b[4];
        int t;
        logic [15:0] pk;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset curve: step at zero, peak one
        push_crisp(-32768); push_crisp(0); push_crisp(1); push_crisp(32767);

        // widest span
        load_curve(SHAPE_STEP, -32768, 32767, 0, 0, PEAK_ONE);
        push_crisp(-32768); push_crisp(-32767); push_crisp(0);
        push_crisp(32766); push_crisp(32767);

        // peak above one, writes to unused indexes
        load_curve(SHAPE_INV_STEP, -100, 100, 0, 0, 16'hFFFF);
        write_reg(SPARE_IDX_LO, 16'hFFFF);
        write_reg(SPARE_IDX_HI, 16'h5A5A);
        push_crisp(-100); push_crisp(-99); push_crisp(99); push_crisp(100);

        load_curve(SHAPE_TRIANGLE, -10, 0, 10, 0, 16'd20000);
        push_crisp(-10); push_crisp(-1); push_crisp(0);
        push_crisp(1); push_crisp(9); push_crisp(10);

        load_curve(SHAPE_TRAPEZE, 0, 5, 10, 20, 16'd32767);
        push_crisp(4); push_crisp(5); push_crisp(10); push_crisp(11); push_crisp(20);

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 65; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 65; end
                default: begin gap_pct = 10; stall_pct = 10; end
            endcase
            case ($urandom_range(3))
                0:
                begin
                    // unordered breakpoints
                    for (int i = 0; i < 4; i++) b[i] = int'($urandom_range(65535)) - 32768;
                end
                1, 2:
                begin
                    for (int i = 0; i < 4; i++) b[i] = int'($urandom_range(65535)) - 32768;
                    for (int i = 0; i < 3; i++)
                        for (int j = 0; j < 3 - i; j++)
                            if (b[j] > b[j + 1])
                            begin
                                t = b[j];
                                b[j] = b[j + 1];
                                b[j + 1] = t;
                            end
                end
                default:
                begin
                    // tight edges, spans of a few counts or none
                    b[0] = int'($urandom_range(65515)) - 32768;
                    for (int i = 1; i < 4; i++) b[i] = b[i - 1] + int'($urandom_range(5));
                end
            endcase
            case ($urandom_range(7))
                0: pk = 16'd0;
                1: pk = PEAK_ONE;
                2: pk = 16'($urandom_range(65535, 32769));
                default: pk = 16'($urandom_range(32768));
            endcase
            load_curve(shape_mode_t'($urandom_range(3)), b[0], b[1], b[2], b[3], pk);
            if ($urandom_range(1))
                write_reg($urandom_range(1) ? SPARE_IDX_HI : SPARE_IDX_LO, 16'($urandom));
            for (int n = 0; n < 100; n++)
            begin
                crisp_backlog.push_back(pick_crisp());
                if (ph == 4 && n == 49)
                    drain();
            end
        end

        drain();
        repeat (30) @(posedge clk);
        $display("covered %0d items over %0d curve settings, all four shapes,", checked, curves);
        $display("with sender idle and receiver stall rates of 0, 10 and 65 percent");
        if (errors == 0 && degree_due.size() == 0)
            $display("fuzzy_membership_eval_core: match");
        else
            $display("fuzzy_membership_eval_core: mismatch");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", degree_due.size());
        $display("fuzzy_membership_eval_core: mismatch");
        $finish;
    end

endmodule
